/* rtl/core/linear_adsr_envelope_assert.svh */
// Assertion macros shared by the envelope RTL.
`ifndef LINEAR_ADSR_ENVELOPE_ASSERT_SVH
`define LINEAR_ADSR_ENVELOPE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LAE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("envelope check failed");

// Next-cycle implication, disabled while reset is low.
`define LAE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("envelope check failed");

`endif

/* rtl/core/lae_pkg.sv */
// Types and constants shared by the linear ADSR envelope.
`default_nettype none

package lae_pkg;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_TRIGGER = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_FORCED  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_ATTACK_LENGTH  = 2'd0,
        REG_DECAY_LENGTH   = 2'd1,
        REG_SUSTAIN_LEVEL  = 2'd2,
        REG_RELEASE_LENGTH = 2'd3
    } t_cfg_reg;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_ATTACK  = 5'b00010,
        PH_DECAY   = 5'b00100,
        PH_SUSTAIN = 5'b01000,
        PH_RELEASE = 5'b10000
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_PUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic take_tick;
        logic apply_event;
        logic mul;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic ramp;
    } t_stat;

    localparam int ATTACK_RESET  = 480;
    localparam int DECAY_RESET   = 4800;
    localparam int SUSTAIN_RESET = 45875;
    localparam int RELEASE_RESET = 9600;

endpackage

`default_nettype wire

/* rtl/core/lae_if.sv */
// Channel interfaces: input items, result words and register writes.
`default_nettype none

interface lae_in_if import lae_pkg::*; #(
    parameter int LENGTH_BITS = 24
);
    logic                   valid;
    logic                   ready;
    t_action                action;
    logic [LENGTH_BITS-1:0] forced_length;

    modport source (output valid, action, forced_length, input ready);
    modport sink   (input valid, action, forced_length, output ready);
endinterface

interface lae_out_if #(
    parameter int LEVEL_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] level;

    modport source (output valid, level, input ready);
    modport sink   (input valid, level, output ready);
endinterface

interface lae_cfg_if import lae_pkg::*; #(
    parameter int DATA_BITS = 24
);
    logic                 valid;
    logic                 ready;
    t_cfg_reg             index;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/linear_adsr_envelope.sv */
// Top level of the linear ADSR envelope generator.
//
//   channel  modport  dir  payload
//   i_in     sink     in   action, forced_length
//   o_out    source   out  level
//   i_cfg    sink     in   index, data (ready always high)
//
// A tick in attack, decay or release runs through these steps:
// accept, one multiply, one restoring divide step per quotient bit, result load.
// A tick in idle or sustain skips to result load; other words apply at accept.
// Reset is synchronous, active low, and restores registers and stage state.
// A result waits in the output register; the next input word is accepted
// meanwhile, and a tick only stalls at its result load while that slot is full.
`default_nettype none

module linear_adsr_envelope import lae_pkg::*; #(
    parameter int LEVEL_BITS  = 16,
    parameter int LENGTH_BITS = 24
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    lae_in_if.sink   i_in,
    lae_out_if.source o_out,
    lae_cfg_if.sink  i_cfg
);

    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    lae_ctrl #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lae_dp #(
        .LEVEL_BITS  (LEVEL_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_action        (i_in.action),
        .i_forced_length (i_in.forced_length),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_level         (o_out.level)
    );

endmodule

`default_nettype wire

/* rtl/core/lae_ctrl.sv */
// Sequencer for the envelope: handshake, multiply and divide steps, result slot.
`default_nettype none

`include "linear_adsr_envelope_assert.svh"

module lae_ctrl import lae_pkg::*; #(
    parameter int LEVEL_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_action i_in_action,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_stat   i_stat,
    output t_cmd    o_cmd
);

    localparam int STEP_BITS = $clog2(LEVEL_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(LEVEL_BITS - 1);

    t_state               r_state, n_state;
    logic [STEP_BITS-1:0] r_step, n_step;
    logic                 r_out_valid, n_out_valid;
    logic                 accept;
    logic                 slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid & o_in_ready;
    assign slot_free   = ~r_out_valid | i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_action == ACT_TICK) begin
                        o_cmd.take_tick = 1'b1;
                        n_state = i_stat.ramp ? S_MUL : S_PUT;
                    end else begin
                        o_cmd.apply_event = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_step    = LAST_STEP;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_PUT;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_PUT: begin
                // hold until the result slot is empty or draining
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.commit | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    `LAE_ASSERT_NXT(a_mul_to_div, i_clk, i_rst_n, r_state == S_MUL, r_state == S_DIV && r_step == LAST_STEP)
    `LAE_ASSERT_NXT(a_div_to_put, i_clk, i_rst_n, r_state == S_DIV && r_step == '0, r_state == S_PUT)
    `LAE_ASSERT_IMP(a_out_from_put, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_PUT))

endmodule

`default_nettype wire

/* rtl/core/lae_dp.sv */
// Envelope datapath: registers, stage state, multiplier and restoring divider.
`default_nettype none

`include "linear_adsr_envelope_assert.svh"

module lae_dp import lae_pkg::*; #(
    parameter int LEVEL_BITS  = 16,
    parameter int LENGTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  t_action                i_action,
    input  logic [LENGTH_BITS-1:0] i_forced_length,
    input  logic                   i_cfg_we,
    input  t_cfg_reg               i_cfg_index,
    input  logic [((LEVEL_BITS > LENGTH_BITS) ? LEVEL_BITS : LENGTH_BITS)-1:0] i_cfg_data,
    output logic [LEVEL_BITS-1:0]  o_level
);

    localparam int PROD_BITS = LEVEL_BITS + LENGTH_BITS;

    // configuration
    logic [LENGTH_BITS-1:0] r_attack_len;
    logic [LENGTH_BITS-1:0] r_decay_len;
    logic [LEVEL_BITS-1:0]  r_sustain;
    logic [LENGTH_BITS-1:0] r_release_len;

    // envelope state
    t_phase                 r_phase, n_phase;
    logic [LEVEL_BITS-1:0]  r_cur, n_cur;
    logic [LEVEL_BITS-1:0]  r_start, n_start;
    logic [LEVEL_BITS-1:0]  r_target, n_target;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [LENGTH_BITS-1:0] r_seg_len, n_seg_len;

    // ramp working registers
    logic                   r_rising;
    logic [LEVEL_BITS-1:0]  r_mag;
    logic [LENGTH_BITS-1:0] r_rem;
    logic [LEVEL_BITS-1:0]  r_quo;
    logic [LEVEL_BITS-1:0]  r_level;

    logic                   ramp;
    logic [PROD_BITS-1:0]   product;
    logic [LENGTH_BITS:0]   rem_ext;
    logic [LENGTH_BITS:0]   rem_diff;
    logic                   rem_ge;
    logic [LEVEL_BITS-1:0]  quo_sat;
    logic [LEVEL_BITS-1:0]  ramp_level;
    logic [LEVEL_BITS-1:0]  commit_level;
    logic [LENGTH_BITS-1:0] count_inc;

    function automatic logic [LENGTH_BITS-1:0] at_least_one(input logic [LENGTH_BITS-1:0] len);
        return (len == '0) ? LENGTH_BITS'(1) : len;
    endfunction

    assign ramp = (r_phase == PH_ATTACK) || (r_phase == PH_DECAY) || (r_phase == PH_RELEASE);
    assign o_stat.ramp = ramp;

    assign product  = PROD_BITS'(r_mag) * PROD_BITS'(r_count);
    assign rem_ext  = {r_rem, r_quo[LEVEL_BITS-1]};
    assign rem_diff = rem_ext - {1'b0, r_seg_len};
    assign rem_ge   = (rem_ext >= {1'b0, r_seg_len});

    assign quo_sat    = (r_quo > r_mag) ? r_mag : r_quo;
    assign ramp_level = r_rising ? (r_start + quo_sat) : (r_start - quo_sat);
    assign count_inc  = r_count + 1'b1;

    always_comb begin
        if (r_phase == PH_SUSTAIN) begin
            commit_level = r_sustain;
        end else if (ramp) begin
            commit_level = ramp_level;
        end else begin
            commit_level = '0;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_cur     = r_cur;
        n_start   = r_start;
        n_target  = r_target;
        n_count   = r_count;
        n_seg_len = r_seg_len;
        if (i_cmd.apply_event) begin
            unique case (i_action)
                ACT_TRIGGER: begin
                    n_phase   = PH_ATTACK;
                    n_start   = r_cur;
                    n_target  = '1;
                    n_count   = '0;
                    n_seg_len = at_least_one(r_attack_len);
                end
                ACT_RELEASE: begin
                    // ignored while idle
                    if (r_phase != PH_IDLE) begin
                        n_phase   = PH_RELEASE;
                        n_start   = r_cur;
                        n_target  = '0;
                        n_count   = '0;
                        n_seg_len = at_least_one(r_release_len);
                    end
                end
                ACT_FORCED: begin
                    n_phase   = PH_RELEASE;
                    n_start   = r_cur;
                    n_target  = '0;
                    n_count   = '0;
                    n_seg_len = at_least_one(i_forced_length);
                end
                ACT_TICK: begin
                end
                default: begin
                end
            endcase
        end else if (i_cmd.commit) begin
            unique case (r_phase) inside
                PH_SUSTAIN: begin
                    n_cur = r_sustain;
                end
                PH_ATTACK, PH_DECAY, PH_RELEASE: begin
                    n_cur   = ramp_level;
                    n_count = count_inc;
                    if (count_inc >= r_seg_len) begin
                        // advance to the next stage
                        if (r_phase == PH_ATTACK) begin
                            n_phase   = PH_DECAY;
                            n_start   = '1;
                            n_target  = r_sustain;
                            n_count   = '0;
                            n_seg_len = at_least_one(r_decay_len);
                        end else if (r_phase == PH_DECAY) begin
                            n_phase   = PH_SUSTAIN;
                            n_cur     = r_sustain;
                            n_start   = r_sustain;
                            n_target  = r_sustain;
                            n_count   = '0;
                            n_seg_len = '0;
                        end else begin
                            n_phase = PH_IDLE;
                            n_cur   = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_len  <= LENGTH_BITS'(ATTACK_RESET);
            r_decay_len   <= LENGTH_BITS'(DECAY_RESET);
            r_sustain     <= LEVEL_BITS'(SUSTAIN_RESET);
            r_release_len <= LENGTH_BITS'(RELEASE_RESET);
            r_phase       <= PH_IDLE;
            r_cur         <= '0;
            r_start       <= '0;
            r_target      <= '0;
            r_count       <= '0;
            r_seg_len     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ATTACK_LENGTH:  r_attack_len  <= i_cfg_data[LENGTH_BITS-1:0];
                    REG_DECAY_LENGTH:   r_decay_len   <= i_cfg_data[LENGTH_BITS-1:0];
                    REG_SUSTAIN_LEVEL:  r_sustain     <= i_cfg_data[LEVEL_BITS-1:0];
                    REG_RELEASE_LENGTH: r_release_len <= i_cfg_data[LENGTH_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            r_phase   <= n_phase;
            r_cur     <= n_cur;
            r_start   <= n_start;
            r_target  <= n_target;
            r_count   <= n_count;
            r_seg_len <= n_seg_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_tick) begin
            r_rising <= (r_target >= r_start);
            r_mag    <= (r_target >= r_start) ? (r_target - r_start) : (r_start - r_target);
        end
        if (i_cmd.mul) begin
            // high part is below the length since count < length
            r_rem <= product[PROD_BITS-1 -: LENGTH_BITS];
            r_quo <= product[LEVEL_BITS-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_diff[LENGTH_BITS-1:0] : rem_ext[LENGTH_BITS-1:0];
            r_quo <= {r_quo[LEVEL_BITS-2:0], rem_ge};
        end
        if (i_cmd.commit) begin
            r_level <= commit_level;
        end
    end

    assign o_level = r_level;

    `LAE_ASSERT_IMP(a_ramp_count, i_clk, i_rst_n, ramp, r_count < r_seg_len)
    `LAE_ASSERT_IMP(a_sustain_len, i_clk, i_rst_n, r_phase == PH_SUSTAIN, r_seg_len == '0)

endmodule

`default_nettype wire

/* tb/linear_adsr_envelope_test.sv */
// Self-checking testbench for the linear ADSR envelope: random words, stalls and register settings.
`default_nettype none

module linear_adsr_envelope_test;
    import lae_pkg::*;

    localparam int          LEVEL_BITS  = 16;
    localparam int          LENGTH_BITS = 24;
    localparam int          SETTLE      = LEVEL_BITS + 8;
    localparam int          QUIET_LIMIT = 4000;
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

    typedef struct packed {
        t_action     act;
        logic [23:0] flen;
    } t_env_word;

    logic i_clk;
    logic i_rst_n;

    lae_in_if  #(.LENGTH_BITS(LENGTH_BITS)) in_ch ();
    lae_out_if #(.LEVEL_BITS(LEVEL_BITS))   out_ch ();
    lae_cfg_if #(.DATA_BITS(LENGTH_BITS))   cfg_ch ();

    linear_adsr_envelope #(
        .LEVEL_BITS (LEVEL_BITS),
        .LENGTH_BITS(LENGTH_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Envelope registers as the block should hold them.
    logic [23:0] reg_attack  = 24'(ATTACK_RESET);
    logic [23:0] reg_decay   = 24'(DECAY_RESET);
    logic [15:0] reg_sustain = 16'(SUSTAIN_RESET);
    logic [23:0] reg_release = 24'(RELEASE_RESET);

    // Envelope stage state.
    t_phase      env_phase = PH_IDLE;
    logic [15:0] env_level = '0;
    logic [15:0] env_from  = '0;
    logic [15:0] env_to    = '0;
    logic [23:0] env_count = '0;
    logic [23:0] env_len   = '0;

    t_env_word   words_pending[$];
    logic [15:0] levels_due[$];
    t_env_word   held_word;
    logic [15:0] due_level;
    logic [15:0] want_level;
    int unsigned words_queued   = 0;
    int unsigned words_taken    = 0;
    int unsigned levels_checked = 0;
    int unsigned settings_used  = 1;
    int unsigned errors         = 0;
    int unsigned send_gap       = 0;
    int unsigned recv_stall     = 0;
    int unsigned quiet          = 0;
    bit          steady         = 1'b0;

    function automatic logic [23:0] min_one(logic [23:0] len);
        return (len == '0) ? 24'd1 : len;
    endfunction

    function automatic void env_start(t_phase ph, logic [15:0] from, logic [15:0] to,
                                      logic [23:0] len);
        env_phase = ph;
        env_from  = from;
        env_to    = to;
        env_count = '0;
        env_len   = len;
    endfunction

    function automatic logic [15:0] ramp_level();
        logic        rising;
        logic [15:0] span;
        logic [63:0] q;
        rising = env_to >= env_from;
        span   = rising ? env_to - env_from : env_from - env_to;
        q      = ({48'd0, span} * {40'd0, env_count}) / {40'd0, env_len};
        if (q > {48'd0, span}) q = {48'd0, span};
        return rising ? env_from + q[15:0] : env_from - q[15:0];
    endfunction

    // Apply one word to the envelope; returns 1 when it yields a level.
    function automatic bit envelope_step(input t_env_word w, output logic [15:0] lvl);
        lvl = '0;
        case (w.act)
            ACT_TRIGGER: begin
                env_start(PH_ATTACK, env_level, FULL_SCALE, min_one(reg_attack));
                return 1'b0;
            end
            ACT_RELEASE: begin
                if (env_phase != PH_IDLE)
                    env_start(PH_RELEASE, env_level, '0, min_one(reg_release));
                return 1'b0;
            end
            ACT_FORCED: begin
                env_start(PH_RELEASE, env_level, '0, min_one(w.flen));
                return 1'b0;
            end
            default: ;
        endcase
        if (env_phase == PH_SUSTAIN) begin
            env_level = reg_sustain;
            lvl = env_level;
            return 1'b1;
        end
        if (env_phase != PH_ATTACK && env_phase != PH_DECAY && env_phase != PH_RELEASE)
            return 1'b1;
        if (env_len != '0) env_level = ramp_level();
        lvl = env_level;
        env_count = env_count + 24'd1;
        if (env_count >= env_len) begin
            case (env_phase)
                PH_ATTACK: env_start(PH_DECAY, FULL_SCALE, reg_sustain, min_one(reg_decay));
                PH_DECAY: begin
                    env_level = reg_sustain;
                    env_start(PH_SUSTAIN, env_level, env_level, '0);
                end
                PH_RELEASE: begin
                    env_phase = PH_IDLE;
                    env_level = '0;
                end
                default: ;
            endcase
        end
        return 1'b1;
    endfunction

    // Mostly short gaps, a few long ones, none while steady.
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Input driver: predict on acceptance, then load the next word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                words_taken++;
                if (envelope_step(held_word, due_level)) levels_due.push_back(due_level);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (words_pending.size() != 0) begin
                    held_word = words_pending.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.action        <= held_word.act;
                    in_ch.forced_length <= held_word.flen;
                    send_gap = draw_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (levels_due.size() == 0) begin
                    $display("%0t: level %0d arrived with none outstanding", $time, out_ch.level);
                    errors++;
                end else begin
                    want_level = levels_due.pop_front();
                    levels_checked++;
                    if (out_ch.level !== want_level) begin
                        $display("%0t: level expected %0d, got %0d", $time, want_level,
                                 out_ch.level);
                        errors++;
                    end
                end
            end
            if (recv_stall != 0) begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                recv_stall = draw_gap();
            end
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet);
            $display("linear_adsr_envelope: mismatch");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic queue_word(t_action a, logic [23:0] f);
        words_pending.push_back('{act: a, flen: f});
        words_queued++;
    endtask

    task automatic queue_ticks(int unsigned n);
        repeat (n) queue_word(ACT_TICK, 24'($urandom));
    endtask

    // Hold until every word is taken and every level has come back.
    task automatic drain();
        while (words_taken != words_queued || levels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Keep valid high across back-to-back writes; caller drops it.
    task automatic write_reg(t_cfg_reg idx, logic [23:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_ATTACK_LENGTH:  reg_attack  = d;
            REG_DECAY_LENGTH:   reg_decay   = d;
            REG_SUSTAIN_LEVEL:  reg_sustain = d[15:0];
            REG_RELEASE_LENGTH: reg_release = d;
            default: ;
        endcase
    endtask

    task automatic load_regs(logic [23:0] atk, logic [23:0] dec, logic [15:0] sus,
                             logic [23:0] rel);
        write_reg(REG_ATTACK_LENGTH, atk);
        write_reg(REG_DECAY_LENGTH, dec);
        write_reg(REG_SUSTAIN_LEVEL, {8'd0, sus});
        write_reg(REG_RELEASE_LENGTH, rel);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    function automatic int unsigned tick_span(logic [23:0] len);
        if (len == '0) return 1;
        return (len > 24'd30) ? 30 : int'(len);
    endfunction

    function automatic logic [23:0] draw_forced();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 24'($urandom_range(0, 12));
        if (r < 85) return 24'($urandom_range(13, 40));
        return 24'($urandom);
    endfunction

    // Mostly whole note sequences with random timing, the rest random words.
    task automatic queue_notes(int unsigned n);
        int unsigned stop;
        int unsigned sa;
        int unsigned sd;
        int unsigned sr;
        stop = words_queued + n;
        sa = tick_span(reg_attack);
        sd = tick_span(reg_decay);
        sr = tick_span(reg_release);
        while (words_queued < stop) begin
            if ($urandom_range(0, 99) < 75) begin
                queue_word(ACT_TRIGGER, 24'($urandom));
                queue_ticks($urandom_range(0, sa + sd + 3));
                if ($urandom_range(0, 9) == 0) begin
                    queue_word(ACT_TRIGGER, 24'($urandom));
                    queue_ticks($urandom_range(0, sa + 2));
                end
                if ($urandom_range(0, 4) == 0) queue_word(ACT_FORCED, draw_forced());
                else queue_word(ACT_RELEASE, 24'($urandom));
                queue_ticks($urandom_range(0, sr + 2));
            end else begin
                queue_word(t_action'($urandom_range(0, 3)), draw_forced());
            end
        end
    endtask

    initial begin : stimulus
        int p;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.action        = ACT_TICK;
        in_ch.forced_length = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_ATTACK_LENGTH;
        cfg_ch.data         = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: idle ticks, ignored release, forced release from idle,
        // retrigger out of release, forced lengths at both ends.
        queue_word(ACT_TICK, 24'hFFFFFF);
        queue_word(ACT_RELEASE, '0);
        queue_ticks(1);
        queue_word(ACT_FORCED, '0);
        queue_ticks(2);
        queue_word(ACT_TRIGGER, '0);
        queue_ticks(2);
        queue_word(ACT_RELEASE, '0);
        queue_ticks(1);
        queue_word(ACT_FORCED, 24'hFFFFFF);
        queue_ticks(1);
        queue_word(ACT_TRIGGER, '0);
        queue_ticks(1);
        queue_word(ACT_FORCED, 24'd1);
        queue_ticks(2);
        drain();

        // Shortest stages, full-scale sustain.
        load_regs(24'd1, 24'd1, 16'hFFFF, 24'd1);
        queue_word(ACT_TRIGGER, '0);
        queue_ticks(4);
        queue_word(ACT_RELEASE, '0);
        queue_ticks(2);
        drain();

        // Zero lengths are raised to one; sustain at zero.
        steady = 1'b1;
        load_regs('0, '0, '0, '0);
        queue_notes(150);
        drain();

        // Longest stages.
        steady = 1'b0;
        load_regs(24'hFFFFFF, 24'hFFFFFF, 16'h8000, 24'hFFFFFF);
        queue_notes(60);
        drain();

        for (p = 0; p < 6; p++) begin
            steady = (p % 3 == 2);
            load_regs(24'($urandom_range(1, 16)), 24'($urandom_range(1, 16)),
                      16'($urandom_range(0, 65535)), 24'($urandom_range(1, 16)));
            queue_notes(140);
            drain();
        end

        $display("sent %0d words under %0d register settings", words_taken, settings_used);
        $display("compared %0d envelope levels, %0d errors", levels_checked, errors);
        if (errors == 0 && levels_due.size() == 0) begin
            $display("linear_adsr_envelope: match");
        end else begin
            $display("linear_adsr_envelope: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/lae_pkg.sv
rtl/core/lae_if.sv
rtl/core/lae_ctrl.sv
rtl/core/lae_dp.sv
rtl/core/linear_adsr_envelope.sv
tb/linear_adsr_envelope_test.sv
